// ===== hdl/sta_pkg.sv =====
// sta_pkg: shared types, constants and the sine table generator
// for the stereo tremolo / auto-pan block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sta_pkg;

  // default sizes
  localparam int SINE_ROM_DEPTH_DEF = 256;
  localparam int SAMPLE_BITS_DEF    = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE = 3'd3;

  // register limits and reset values
  localparam logic [21:0] STEP_MIN   = 22'd974;
  localparam logic [21:0] STEP_MAX   = 22'd2921746;
  localparam logic [21:0] STEP_RESET = 22'd97392;
  localparam logic [15:0] DEPTH_MAX   = 16'd32768;
  localparam logic [15:0] DEPTH_RESET = 16'd16384;

  // wave shape codes, the remaining code plays as sine
  localparam logic [1:0] SHAPE_SINE   = 2'd0;
  localparam logic [1:0] SHAPE_SQUARE = 2'd1;
  localparam logic [1:0] SHAPE_TRI    = 2'd2;

  // pi in Q30
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR_L,
    ST_ATT_L,
    ST_ATT_R,
    ST_SCALE_L,
    ST_SCALE_R,
    ST_DONE
  } sta_state_t;

  // sin(x) for x in Q30 by a Taylor series through x^11, scaled to 32767
  function automatic logic [14:0] sine_poly(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    if (sum < 0) begin
      v = 64'd0;
    end else begin
      v = (unsigned'(sum) * 64'd32767 + 64'd536870912) >> 30;
    end
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/stereo_tremolo_autopan.sv =====
// Sequence: an accepted frame runs ADDR_L, ATT_L, ATT_R, SCALE_L, SCALE_R, DONE
// and is registered out on leaving DONE; in_stall is high while a frame is in
// work, so a new frame waits for the last to leave DONE. Rate is set by the
// single shared multiplier, used four times per frame (two attenuations, two
// sample scalings), plus two sine table reads. Reset (rst, synchronous):
// registers return to their defaults, LFO phase is 0, no result pending.
// Holds the whole block; depends on sta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stereo_tremolo_autopan #(
  parameter int SINE_ROM_DEPTH = sta_pkg::SINE_ROM_DEPTH_DEF,
  parameter int SAMPLE_BITS    = sta_pkg::SAMPLE_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  // configuration writes
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [sta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [sta_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input frames
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire signed [SAMPLE_BITS-1:0]    left_in,
  input  wire signed [SAMPLE_BITS-1:0]    right_in,
  // output frames
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic signed [SAMPLE_BITS-1:0]   left_out,
  output logic signed [SAMPLE_BITS-1:0]   right_out
);

  import sta_pkg::*;

  localparam int IW = (SINE_ROM_DEPTH > 1) ? $clog2(SINE_ROM_DEPTH) : 1;
  localparam int PW_IDX = 30 + IW + 1;
  localparam int AW = (SAMPLE_BITS > 17) ? SAMPLE_BITS : 17;
  localparam int BW = 18;
  localparam int PW = AW + BW;

  // configuration registers
  logic [21:0] phase_step;
  logic [15:0] mod_depth;
  logic [1:0]  wave_shape;
  logic        stereo_mode;

  // state
  sta_state_t state, state_next;
  logic [31:0] lfo_phase;

  // datapath registers
  logic signed [SAMPLE_BITS-1:0] left_q, right_q, left_res;
  logic signed [BW-1:0]          gain_l, gain_r;
  logic signed [PW-1:0]          mul_p;
  logic [14:0]                   rom_q;

  // control decode
  logic in_req, out_free, load_out;

  // sine table, built at elaboration
  logic [14:0] sine_rom [SINE_ROM_DEPTH];

  for (genvar k = 0; k < SINE_ROM_DEPTH; k++) begin : g_rom
    localparam logic [63:0] XK =
      (64'(2 * k + 1) * PI_Q30) / (64'(4 * SINE_ROM_DEPTH));
    assign sine_rom[k] = sine_poly(XK);
  end

  assign cfg_ready = 1'b1;

  // configuration writes, rate and depth saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step  <= STEP_RESET;
      mod_depth   <= DEPTH_RESET;
      wave_shape  <= SHAPE_SINE;
      stereo_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PHASE_STEP: begin
          if (cfg_data < STEP_MIN) begin
            phase_step <= STEP_MIN;
          end else if (cfg_data > STEP_MAX) begin
            phase_step <= STEP_MAX;
          end else begin
            phase_step <= cfg_data;
          end
        end
        REG_MOD_DEPTH: begin
          if (cfg_data[15:0] > DEPTH_MAX) begin
            mod_depth <= DEPTH_MAX;
          end else begin
            mod_depth <= cfg_data[15:0];
          end
        end
        REG_WAVE_SHAPE:  wave_shape  <= cfg_data[1:0];
        REG_STEREO_MODE: stereo_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // phases of the two channels
  logic [31:0] phase_l, phase_r, rom_ph, wave_ph;
  assign phase_l = lfo_phase;
  assign phase_r = stereo_mode ? {~lfo_phase[31], lfo_phase[30:0]} : lfo_phase;
  assign rom_ph  = (state == ST_ADDR_L) ? phase_l : phase_r;
  assign wave_ph = (state == ST_ATT_R) ? phase_r : phase_l;

  // table index: quarter phase scaled to the table, mirrored in odd quadrants
  logic [PW_IDX-1:0] idx_prod;
  logic [IW-1:0]     idx, rom_addr;
  assign idx_prod = PW_IDX'(rom_ph[29:0]) * PW_IDX'(SINE_ROM_DEPTH);
  assign idx      = idx_prod[30 +: IW];
  assign rom_addr = rom_ph[30] ? (IW'(SINE_ROM_DEPTH - 1) - idx) : idx;

  // registered table read
  always_ff @(posedge clk) begin
    rom_q <= sine_rom[rom_addr];
  end

  // wave value for the channel in work
  logic signed [18:0] wave, sine_w, tri_p4, diff;
  assign sine_w = wave_ph[31] ? -$signed({4'b0, rom_q}) : $signed({4'b0, rom_q});
  assign tri_p4 = $signed({2'b0, wave_ph[31:17], 2'b0});

  always_comb begin
    unique case (wave_shape)
      SHAPE_SQUARE: wave = wave_ph[31] ? -19'sd32768 : 19'sd32768;
      SHAPE_TRI:    wave = wave_ph[31] ? (19'sd98304 - tri_p4) : (tri_p4 - 19'sd32768);
      default:      wave = sine_w;
    endcase
  end

  assign diff = 19'sd32768 - wave;

  // shared multiplier operands
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;

  always_comb begin
    unique case (state)
      ST_ATT_L, ST_ATT_R: begin
        mul_a = $signed(AW'(mod_depth));
        mul_b = diff[BW-1:0];
      end
      ST_SCALE_L: begin
        mul_a = AW'(left_q);
        mul_b = gain_l;
      end
      ST_SCALE_R: begin
        mul_a = AW'(right_q);
        mul_b = gain_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // gain from the attenuation product
  logic signed [BW-1:0] gain_new;
  assign gain_new = $signed({1'b0, 17'd32768 - {1'b0, mul_p[31:16]}});

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_req) state_next = ST_ADDR_L;
      ST_ADDR_L:  state_next = ST_ATT_L;
      ST_ATT_L:   state_next = ST_ATT_R;
      ST_ATT_R:   state_next = ST_SCALE_L;
      ST_SCALE_L: state_next = ST_SCALE_R;
      ST_SCALE_R: state_next = ST_DONE;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // handshake decode
  always_comb begin
    in_stall = (state != ST_IDLE);
    in_req   = in_valid && !in_stall;
    out_free = !(out_valid && out_stall);
    load_out = (state == ST_DONE) && out_free;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lfo_phase <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        lfo_phase <= lfo_phase + {10'b0, phase_step};
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath, the right product holds while the result waits
  always_ff @(posedge clk) begin
    if (in_req) begin
      left_q  <= left_in;
      right_q <= right_in;
    end
    if (state != ST_DONE) begin
      mul_p <= mul_a * mul_b;
    end
    if (state == ST_ATT_R) begin
      gain_l <= gain_new;
    end
    if (state == ST_SCALE_L) begin
      gain_r <= gain_new;
    end
    if (state == ST_SCALE_R) begin
      left_res <= mul_p[15 +: SAMPLE_BITS];
    end
    if (load_out) begin
      left_out  <= left_res;
      right_out <= mul_p[15 +: SAMPLE_BITS];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sta_checker.sv =====
// sta_checker: port-level assertions for stereo_tremolo_autopan
// and the bind that attaches them; depends on sta_pkg
`timescale 1ns / 1ps
`default_nettype none

module sta_props #(
  parameter int SAMPLE_BITS = sta_pkg::SAMPLE_BITS_DEF
) (
  input wire                   clk,
  input wire                   rst,
  input wire                   in_valid,
  input wire                   in_stall,
  input wire                   out_valid,
  input wire                   out_stall,
  input wire [SAMPLE_BITS-1:0] left_out,
  input wire [SAMPLE_BITS-1:0] right_out
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(left_out) && $stable(right_out))
    else $error("stalled result changed");

  // a frame in work blocks the next request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after request");

  // no result appears right after a request
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too early");

  // reset leaves no result pending and the input open
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("state after reset");

endmodule

bind stereo_tremolo_autopan sta_props #(.SAMPLE_BITS(SAMPLE_BITS)) u_sta_props (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .left_out  (left_out),
  .right_out (right_out)
);

`default_nettype wire
